[src/vrt_pkg.sv]
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and codes for the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

    // Command codes of an input item
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_ANSWER = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    // Step sign codes (same coding as a 2-bit signed unit)
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_POS  = 2'd1;
    localparam logic [1:0] STEP_NEG  = 2'd3;

    // Axis codes: none (origin cell) and z
    localparam logic [1:0] AXIS_NONE = 2'd3;
    localparam logic [1:0] AXIS_Z    = 2'd2;

    // Saturated (infinite) distance
    localparam logic [31:0] INF32 = 32'hFFFF_FFFF;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ACC,
        S_ROOT,
        S_ROOT_WAIT,
        S_AXIS,
        S_SPC_WAIT,
        S_FMUL,
        S_FDIV,
        S_FDIV_WAIT,
        S_NEXT
    } t_state;

    // Operations of the shared divide / root unit
    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_op;

    // Request to the shared unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_arith_req;

endpackage

[src/vrt_arith.sv]
// ----------------------------------------------------------------------------
// vrt_arith
// Shared bit-serial unit: 64/32 restoring divide (one quotient bit a cycle)
// or 64-bit floor square root (one root bit a cycle).
// ----------------------------------------------------------------------------
module vrt_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vrt_pkg::t_arith_req i_req,
    input  logic [63:0]         i_a,
    input  logic [31:0]         i_b,
    output logic                o_done,
    output logic [63:0]         o_result
);
    import vrt_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_op         r_op;
    logic [6:0]  r_cnt;
    logic [63:0] r_num;
    logic [34:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_div;

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;
    logic [34:0] n_rem;

    // One step of the selected recurrence
    always_comb begin
        if (r_op == OP_SQRT) begin
            rem_sh = {r_rem[32:0], r_num[63:62]};
            trial  = {1'b0, r_quo[31:0], 2'b01};
        end else begin
            rem_sh = {1'b0, r_rem[32:0], r_num[63]};
            trial  = {3'b000, r_div};
        end
        ge    = (rem_sh >= trial);
        n_rem = ge ? (rem_sh - trial) : rem_sh;
    end

    // Control: count steps and flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == OP_SQRT) ? 7'd31 : 7'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift one digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_num <= i_a;
            r_div <= i_b;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= (r_op == OP_SQRT) ? {r_num[61:0], 2'b00} : {r_num[62:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_quo;

endmodule

[src/voxel_ray_traversal.sv]
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// Amanatides-Woo walk of a ray through unit cells, with cell contents fetched
// through query / answer items.
// ----------------------------------------------------------------------------
// Block-id answer: result registered in the cycle after the item; one per cycle
//   while the output is not stalled. Start command: set up on the shared
//   bit-serial unit (a 32-step root and six 64-step divides; an axis that does
//   not move skips its two divides); a zero direction misses in the cycle after the item.
// No item is taken while a start is being set up.
// Reset (synchronous, active low) clears the sequencer, the active flag and
//   the output valid; the last crossed axis returns to the origin-cell code.
// ----------------------------------------------------------------------------
module voxel_ray_traversal #(
    parameter int FRAC_BITS = 16,
    parameter int CELL_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic [30:0]        i_max_distance,
    input  logic [15:0]        i_block_id,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_cell_x,
    output logic signed [15:0] o_cell_y,
    output logic signed [15:0] o_cell_z,
    output logic signed [1:0]  o_normal_x,
    output logic signed [1:0]  o_normal_y,
    output logic signed [1:0]  o_normal_z,
    output logic [30:0]        o_hit_distance
);
    import vrt_pkg::*;

    // Control state
    t_state r_state, n_state;
    logic   r_active;
    logic   r_out_valid;
    logic [1:0] r_last_axis;
    logic [1:0] r_ax;

    // Ray state
    logic signed [CELL_BITS-1:0] r_cell [3];
    logic [1:0]            r_step [3];
    logic [31:0]           r_next [3];
    logic [31:0]           r_space [3];
    logic [31:0]           r_limit;
    logic [31:0]           r_entry;

    // Setup working registers
    logic [31:0]           r_mag [3];
    logic                  r_neg [3];
    logic [FRAC_BITS-1:0]  r_frac [3];
    logic [63:0]           r_sum;
    logic [63:0]           r_prod;
    logic [31:0]           r_len;

    // Output register
    logic [1:0]                  r_o_kind;
    logic signed [15:0]          r_o_cell [3];
    logic signed [1:0]           r_o_normal [3];
    logic [30:0]                 r_o_dist;

    // Shared unit and multiplier operands
    t_arith_req  arith_req;
    logic [63:0] arith_a;
    logic        arith_done;
    logic [63:0] arith_res;
    logic [31:0] arith_sat;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] f_val;

    // Handshake
    logic in_acc;
    logic is_start;
    logic dir_zero;

    // Answer path
    logic [1:0]  ans_ax;
    logic [31:0] ans_t;
    logic [32:0] ans_sum;
    logic        ans_miss;
    logic        ans_hit;

    // Result to load
    logic                        res_valid;
    logic [1:0]                  res_kind;
    logic                        res_use_cell;
    logic signed [CELL_BITS-1:0] res_cell [3];
    logic signed [1:0]           res_normal [3];
    logic [30:0]                 res_dist;

    vrt_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (arith_req),
        .i_a      (arith_a),
        .i_b      (r_mag[r_ax]),
        .o_done   (arith_done),
        .o_result (arith_res)
    );

    assign arith_sat = (arith_res[63:32] != 32'd0) ? INF32 : arith_res[31:0];

    // Take an item only when idle and the output register can move
    assign o_stall  = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign in_acc   = i_valid && !o_stall;
    assign is_start = (i_command == CMD_START);
    assign dir_zero = (i_dir_x == 32'sd0) && (i_dir_y == 32'sd0) && (i_dir_z == 32'sd0);

    // Pick the nearest boundary, ties to x then y
    always_comb begin
        ans_ax = 2'd0;
        if (r_next[1] < r_next[0]) begin
            ans_ax = (r_next[2] < r_next[1]) ? 2'd2 : 2'd1;
        end else if (r_next[2] < r_next[0]) begin
            ans_ax = 2'd2;
        end
        ans_t    = r_next[ans_ax];
        ans_sum  = {1'b0, ans_t} + {1'b0, r_space[ans_ax]};
        ans_miss = (ans_t > r_limit);
        ans_hit  = (i_block_id != 16'd0);
    end

    // Build the result of this cycle
    always_comb begin
        res_valid    = 1'b0;
        res_kind     = KIND_QUERY;
        res_use_cell = 1'b0;
        res_dist     = '0;
        for (int a = 0; a < 3; a++) begin
            res_cell[a]   = r_cell[a];
            res_normal[a] = 2'sd0;
        end
        if (r_state == S_IDLE && in_acc) begin
            if (is_start) begin
                if (dir_zero) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_MISS;
                end
            end else if (r_active) begin
                res_valid = 1'b1;
                if (ans_hit) begin
                    res_kind     = KIND_HIT;
                    res_use_cell = 1'b1;
                    res_dist     = r_entry[30:0];
                    if (r_last_axis != AXIS_NONE) begin
                        res_normal[r_last_axis] = $signed(2'(-r_step[r_last_axis]));
                    end
                end else if (ans_miss) begin
                    res_kind = KIND_MISS;
                end else begin
                    res_kind     = KIND_QUERY;
                    res_use_cell = 1'b1;
                    if (r_step[ans_ax] == STEP_POS) begin
                        res_cell[ans_ax] = r_cell[ans_ax] + $signed(CELL_BITS'(1));
                    end else if (r_step[ans_ax] == STEP_NEG) begin
                        res_cell[ans_ax] = r_cell[ans_ax] - $signed(CELL_BITS'(1));
                    end
                end
            end
        end else if (r_state == S_NEXT && r_ax == AXIS_Z) begin
            res_valid    = 1'b1;
            res_kind     = KIND_QUERY;
            res_use_cell = 1'b1;
        end
    end

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_start && !dir_zero) n_state = S_SQUARE;
            end
            S_SQUARE:    n_state = S_ACC;
            S_ACC:       n_state = (r_ax == AXIS_Z) ? S_ROOT : S_SQUARE;
            S_ROOT:      n_state = S_ROOT_WAIT;
            S_ROOT_WAIT: begin
                if (arith_done) n_state = S_AXIS;
            end
            S_AXIS:      n_state = (r_mag[r_ax] == 32'd0) ? S_NEXT : S_SPC_WAIT;
            S_SPC_WAIT: begin
                if (arith_done) n_state = S_FMUL;
            end
            S_FMUL:      n_state = S_FDIV;
            S_FDIV:      n_state = S_FDIV_WAIT;
            S_FDIV_WAIT: begin
                if (arith_done) n_state = S_NEXT;
            end
            S_NEXT:      n_state = (r_ax == AXIS_Z) ? S_IDLE : S_AXIS;
            default:     n_state = S_IDLE;
        endcase
    end

    // Sequencer: drive the shared unit and the multiplier
    always_comb begin
        arith_req.start = 1'b0;
        arith_req.op    = OP_DIV;
        arith_a         = r_prod;
        f_val = r_neg[r_ax] ? 32'(r_frac[r_ax])
                            : (32'd1 << FRAC_BITS) - 32'(r_frac[r_ax]);
        mul_a = r_mag[r_ax];
        mul_b = r_mag[r_ax];
        unique case (r_state)
            S_ROOT: begin
                arith_req.start = 1'b1;
                arith_req.op    = OP_SQRT;
                arith_a         = r_sum;
            end
            S_AXIS: begin
                arith_req.start = (r_mag[r_ax] != 32'd0);
                arith_a         = 64'(r_len) << FRAC_BITS;
            end
            S_FMUL: begin
                mul_a = f_val;
                mul_b = r_len;
            end
            S_FDIV: begin
                arith_req.start = 1'b1;
            end
            default: begin
                arith_req.start = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_axis <= AXIS_NONE;
            r_ax        <= '0;
        end else begin
            r_state <= n_state;
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE && in_acc) begin
                if (is_start) begin
                    r_active    <= 1'b0;
                    r_last_axis <= AXIS_NONE;
                    r_ax        <= '0;
                end else if (r_active) begin
                    if (ans_hit || ans_miss) begin
                        r_active <= 1'b0;
                    end else begin
                        r_last_axis <= ans_ax;
                    end
                end
            end
            // Step the axis counter through setup
            if (r_state == S_ACC) begin
                r_ax <= (r_ax == AXIS_Z) ? 2'd0 : r_ax + 2'd1;
            end
            if (r_state == S_NEXT) begin
                if (r_ax == AXIS_Z) begin
                    r_active <= 1'b1;
                end else begin
                    r_ax <= r_ax + 2'd1;
                end
            end
        end
    end

    // Ray and setup payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            if (is_start) begin
                r_mag[0]  <= i_dir_x[31] ? 32'(-i_dir_x) : 32'(i_dir_x);
                r_mag[1]  <= i_dir_y[31] ? 32'(-i_dir_y) : 32'(i_dir_y);
                r_mag[2]  <= i_dir_z[31] ? 32'(-i_dir_z) : 32'(i_dir_z);
                r_neg[0]  <= i_dir_x[31];
                r_neg[1]  <= i_dir_y[31];
                r_neg[2]  <= i_dir_z[31];
                r_frac[0] <= i_origin_x[FRAC_BITS-1:0];
                r_frac[1] <= i_origin_y[FRAC_BITS-1:0];
                r_frac[2] <= i_origin_z[FRAC_BITS-1:0];
                r_cell[0] <= CELL_BITS'(i_origin_x >>> FRAC_BITS);
                r_cell[1] <= CELL_BITS'(i_origin_y >>> FRAC_BITS);
                r_cell[2] <= CELL_BITS'(i_origin_z >>> FRAC_BITS);
                r_limit   <= {1'b0, i_max_distance};
                r_entry   <= '0;
                r_sum     <= '0;
            end else if (r_active && !ans_hit && !ans_miss) begin
                r_cell[ans_ax] <= res_cell[ans_ax];
                r_next[ans_ax] <= ans_sum[32] ? INF32 : ans_sum[31:0];
                r_entry        <= ans_t;
            end
        end
        // Multiply, one product per cycle in the square and scale states
        if (r_state == S_SQUARE || r_state == S_FMUL) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
        if (r_state == S_ACC) begin
            r_sum <= r_sum + r_prod;
        end
        if (r_state == S_ROOT_WAIT && arith_done) begin
            r_len <= arith_res[31:0];
        end
        if (r_state == S_AXIS) begin
            if (r_mag[r_ax] == 32'd0) begin
                r_step[r_ax]  <= STEP_NONE;
                r_next[r_ax]  <= INF32;
                r_space[r_ax] <= INF32;
            end else begin
                r_step[r_ax] <= r_neg[r_ax] ? STEP_NEG : STEP_POS;
            end
        end
        if (r_state == S_SPC_WAIT && arith_done) begin
            r_space[r_ax] <= arith_sat;
        end
        if (r_state == S_FDIV_WAIT && arith_done) begin
            r_next[r_ax] <= arith_sat;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_o_kind <= res_kind;
            r_o_dist <= res_dist;
            for (int a = 0; a < 3; a++) begin
                r_o_cell[a]   <= res_use_cell ? 16'(res_cell[a]) : 16'sd0;
                r_o_normal[a] <= res_normal[a];
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_o_kind;
    assign o_cell_x       = r_o_cell[0];
    assign o_cell_y       = r_o_cell[1];
    assign o_cell_z       = r_o_cell[2];
    assign o_normal_x     = r_o_normal[0];
    assign o_normal_y     = r_o_normal[1];
    assign o_normal_z     = r_o_normal[2];
    assign o_hit_distance = r_o_dist;

`ifndef SYNTHESIS
    // The shared unit only finishes while the sequencer waits on it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        arith_done |-> (r_state == S_ROOT_WAIT || r_state == S_SPC_WAIT ||
                        r_state == S_FDIV_WAIT))
        else $error("shared unit finished outside a wait state");

    // A pending miss never coexists with a live ray
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_kind == KIND_MISS) |-> !r_active)
        else $error("miss reported while a ray is still active");

    // The ray only ever crosses along an axis that moves
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_last_axis != AXIS_NONE) |-> (r_step[r_last_axis] != STEP_NONE))
        else $error("crossed a boundary on a still axis");
`endif

endmodule

[sim/voxel_ray_traversal_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal_tb
// Self-checking bench for the voxel ray walker. Rays are started with directed
// and random origins and directions, then walked by answering cell queries
// with air or a solid block id. A scoreboard predicts every query, hit and
// miss and compares each result item field by field, under several phases of
// sender idling and receiver stalling.
// ----------------------------------------------------------------------------
import vrt_pkg::*;

typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] cell_z;
    logic signed [1:0]  normal_x;
    logic signed [1:0]  normal_y;
    logic signed [1:0]  normal_z;
    logic [30:0]        hit_distance;
} t_walk_result;

class walk_scoreboard;
    localparam int FRAC = 16;

    bit          active;
    logic [15:0] cur_cell [3];
    logic [1:0]  sgn [3];
    logic [31:0] crossing [3];
    logic [31:0] spacing [3];
    logic [31:0] limit;
    logic [31:0] entry;
    logic [1:0]  axis;
    t_walk_result pending [$];
    int errors;

    function new();
        active = 0;
        for (int a = 0; a < 3; a++) begin
            cur_cell[a] = 0; sgn[a] = STEP_NONE; crossing[a] = 0; spacing[a] = 0;
        end
        limit = 0; entry = 0; axis = AXIS_NONE; errors = 0;
    endfunction

    static function logic [63:0] root64(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    static function logic [31:0] clip32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? INF32 : v[31:0];
    endfunction

    function t_walk_result make(logic [1:0] k, bit with_cell);
        t_walk_result r;
        r = '0;
        r.kind = k;
        if (with_cell) begin
            r.cell_x = cur_cell[0]; r.cell_y = cur_cell[1]; r.cell_z = cur_cell[2];
        end
        return r;
    endfunction

    // Note an accepted input item and queue the result it causes
    function void note_item(logic cmd, logic [31:0] org [3], logic [31:0] dir [3],
                            logic [30:0] maxd, logic [15:0] bid);
        logic [63:0] mag [3];
        logic [63:0] sum, len, f;
        logic [31:0] t;
        logic [31:0] fr;
        t_walk_result r;
        int ax;
        if (cmd == CMD_START) begin
            sum = 0;
            for (int a = 0; a < 3; a++) begin
                mag[a] = dir[a][31] ? (64'd1 << 32) - dir[a] : {32'd0, dir[a]};
                sum = sum + mag[a] * mag[a];
            end
            if (sum == 0) begin
                active = 0;
                pending.push_back(make(KIND_MISS, 0));
                return;
            end
            len = root64(sum);
            for (int a = 0; a < 3; a++) begin
                cur_cell[a] = org[a][31:16];
                fr = {16'd0, org[a][15:0]};
                if (mag[a] == 0) begin
                    sgn[a] = STEP_NONE; crossing[a] = INF32; spacing[a] = INF32;
                end else begin
                    if (dir[a][31]) begin
                        sgn[a] = STEP_NEG; f = fr;
                    end else begin
                        sgn[a] = STEP_POS; f = (64'd1 << FRAC) - fr;
                    end
                    spacing[a] = clip32((len << FRAC) / mag[a]);
                    crossing[a] = clip32((f * len) / mag[a]);
                end
            end
            limit = {1'b0, maxd};
            entry = 0;
            axis = AXIS_NONE;
            active = 1;
            pending.push_back(make(KIND_QUERY, 1));
            return;
        end
        if (!active) return;
        if (bid != 0) begin
            r = make(KIND_HIT, 1);
            if (axis != AXIS_NONE) begin
                case (axis)
                    2'd0: r.normal_x = -$signed(sgn[0]);
                    2'd1: r.normal_y = -$signed(sgn[1]);
                    default: r.normal_z = -$signed(sgn[2]);
                endcase
            end
            r.hit_distance = entry[30:0];
            active = 0;
            pending.push_back(r);
            return;
        end
        // Pick the nearest boundary, ties to x then y
        ax = 0;
        if (crossing[1] < crossing[0]) ax = (crossing[2] < crossing[1]) ? 2 : 1;
        else if (crossing[2] < crossing[0]) ax = 2;
        t = crossing[ax];
        if (t > limit) begin
            active = 0;
            pending.push_back(make(KIND_MISS, 0));
            return;
        end
        if (sgn[ax] == STEP_POS) cur_cell[ax] = cur_cell[ax] + 16'd1;
        else if (sgn[ax] == STEP_NEG) cur_cell[ax] = cur_cell[ax] - 16'd1;
        crossing[ax] = clip32({32'd0, t} + {32'd0, spacing[ax]});
        entry = t;
        axis = ax[1:0];
        pending.push_back(make(KIND_QUERY, 1));
    endfunction

    // Compare one result item with the oldest expectation
    function void check_result(t_walk_result got);
        t_walk_result exp_r;
        if (pending.size() == 0) begin
            $error("result with nothing expected: kind %0d", got.kind);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.kind != exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, got.kind); errors++;
        end
        if (got.cell_x != exp_r.cell_x) begin
            $error("cell_x: expected %0d, got %0d", exp_r.cell_x, got.cell_x); errors++;
        end
        if (got.cell_y != exp_r.cell_y) begin
            $error("cell_y: expected %0d, got %0d", exp_r.cell_y, got.cell_y); errors++;
        end
        if (got.cell_z != exp_r.cell_z) begin
            $error("cell_z: expected %0d, got %0d", exp_r.cell_z, got.cell_z); errors++;
        end
        if (got.normal_x != exp_r.normal_x) begin
            $error("normal_x: expected %0d, got %0d", exp_r.normal_x, got.normal_x);
            errors++;
        end
        if (got.normal_y != exp_r.normal_y) begin
            $error("normal_y: expected %0d, got %0d", exp_r.normal_y, got.normal_y);
            errors++;
        end
        if (got.normal_z != exp_r.normal_z) begin
            $error("normal_z: expected %0d, got %0d", exp_r.normal_z, got.normal_z);
            errors++;
        end
        if (got.hit_distance != exp_r.hit_distance) begin
            $error("hit_distance: expected %0d, got %0d",
                   exp_r.hit_distance, got.hit_distance);
            errors++;
        end
    endfunction
endclass

module voxel_ray_traversal_tb;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic               i_command = 0;
    logic signed [31:0] i_origin_x = 0, i_origin_y = 0, i_origin_z = 0;
    logic signed [31:0] i_dir_x = 0, i_dir_y = 0, i_dir_z = 0;
    logic [30:0]        i_max_distance = 0;
    logic [15:0]        i_block_id = 0;
    logic               out_valid;
    logic               out_stall = 0;
    t_walk_result       res;

    walk_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_count = 0;

    always #5 i_clk = ~i_clk;

    voxel_ray_traversal i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_command(i_command),
        .i_origin_x(i_origin_x), .i_origin_y(i_origin_y), .i_origin_z(i_origin_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_max_distance(i_max_distance), .i_block_id(i_block_id),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_kind(res.kind),
        .o_cell_x(res.cell_x), .o_cell_y(res.cell_y), .o_cell_z(res.cell_z),
        .o_normal_x(res.normal_x), .o_normal_y(res.normal_y),
        .o_normal_z(res.normal_z),
        .o_hit_distance(res.hit_distance)
    );

    // Check results, drive receiver stall, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) sb.check_result(res);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
            else idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("[voxel_ray_traversal] ERROR");
                $finish;
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Present one item, hold it until accepted, then note it
    task automatic send_item(logic cmd, logic [31:0] o [3], logic [31:0] d [3],
                             logic [30:0] maxd, logic [15:0] bid);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        i_command <= cmd;
        i_origin_x <= o[0]; i_origin_y <= o[1]; i_origin_z <= o[2];
        i_dir_x <= d[0]; i_dir_y <= d[1]; i_dir_z <= d[2];
        i_max_distance <= maxd;
        i_block_id <= bid;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sb.note_item(cmd, o, d, maxd, bid);
    endtask

    task automatic start_ray(logic [31:0] o [3], logic [31:0] d [3], logic [30:0] maxd);
        send_item(CMD_START, o, d, maxd, 16'd0);
    endtask

    task automatic answer(logic [15:0] bid);
        logic [31:0] o [3];
        logic [31:0] d [3];
        for (int a = 0; a < 3; a++) begin
            o[a] = $urandom; d[a] = $urandom;
        end
        send_item(CMD_ANSWER, o, d, 31'($urandom), bid);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Random direction: mostly moderate, some with zero or extreme axes
    function automatic logic [31:0] rand_dir();
        case ($urandom_range(9))
            0: return 0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return $urandom;
            default: return $signed($urandom_range(2 << 16)) - (1 << 16);
        endcase
    endfunction

    // One walk: start, then answer mostly air for up to 12 steps, then usually a solid block
    task automatic random_ray(inout int items);
        logic [31:0] o [3];
        logic [31:0] d [3];
        int steps;
        for (int a = 0; a < 3; a++) begin
            o[a] = ($urandom_range(3) == 0) ? $urandom
                 : $signed($urandom_range(32'h0010_0000)) - 32'h0008_0000;
            if ($urandom_range(7) == 0) o[a][15:0] = 0;
            d[a] = rand_dir();
        end
        start_ray(o, d, ($urandom_range(4) == 0) ? 31'($urandom)
                                                 : 31'($urandom_range(32'h0010_0000)));
        items++;
        steps = $urandom_range(12);
        for (int s = 0; s < steps; s++) begin
            answer(($urandom_range(19) == 0) ? 16'($urandom) : 16'd0);
            items++;
        end
        if ($urandom_range(5) != 0) begin
            answer(($urandom_range(1) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
            items++;
        end
    endtask

    initial begin
        logic [31:0] o [3];
        logic [31:0] d [3];
        int items;
        sb = new();
        items = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: answer with no active ray, zero direction
        answer(16'd5);
        o = '{32'h0, 32'h0, 32'h0};
        d = '{32'h0, 32'h0, 32'h0};
        start_ray(o, d, 31'h7FFF_FFFF);
        // Origin cell hit, then a walk along +x with air
        o = '{32'h0001_8000, 32'h0, 32'hFFFF_0000};
        d = '{32'h0001_0000, 32'h0, 32'h0};
        start_ray(o, d, 31'h0005_0000);
        answer(16'hFFFF);
        start_ray(o, d, 31'h0002_0000);
        repeat (4) answer(16'd0);
        // Negative direction from a boundary, diagonal ties, then hit
        o = '{32'h0002_0000, 32'h0003_0000, 32'h8000_0000};
        d = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
        start_ray(o, d, 31'h7FFF_FFFF);
        repeat (4) answer(16'd0);
        answer(16'd1);
        // Restart while active, extremes and cell wrap
        o = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        d = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        start_ray(o, d, 31'h7FFF_FFFF);
        answer(16'd0);
        start_ray(o, d, 31'h0);
        answer(16'd0);
        answer(16'd0);
        drain();

        // Random phases: free run, sender idle, receiver stall, both
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = (p == 1) ? 64 : (p == 3) ? 9 : 0;
            recv_stall_pct = (p == 2) ? 64 : (p == 3) ? 9 : 0;
            while (items < (p + 1) * 185) random_ray(items);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        in_valid <= 0;
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[voxel_ray_traversal] OK");
        end else begin
            $display("[voxel_ray_traversal] ERROR");
        end
        $finish;
    end
endmodule
